// ===== hw/rtl/modular_add_mul_pow_unit_defines.svh =====
// assertion macros used by the checker file of the modular arithmetic unit
`ifndef MODULAR_ADD_MUL_POW_UNIT_DEFINES_SVH
`define MODULAR_ADD_MUL_POW_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define MAMP_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define MAMP_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/mamp_pkg.sv =====
// package: field widths, action and status codes, sequencer state type
`default_nettype none

package mamp_pkg;

  localparam int FIELD_W  = 64;
  localparam int ACTION_W = 2;

  localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MUL = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POW = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_BAD = 2'd3;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_REDA = 6'b000010,
    S_REDB = 6'b000100,
    S_ADD  = 6'b001000,
    S_MUL  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/modular_add_mul_pow_unit.sv =====
// top level: iterative modular add, multiply and power unit
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser action, tdata operand_a, operand_b, modulus
//  m_*     | out | m_tvalid/m_tready  | tuser status, tdata value
//
// operand_a, and operand_b too for add, is reduced by a bit-serial remainder;
// products and powers then take one double-and-add step of the shared modular
// adder lanes per cycle; a zero modulus or unknown action is answered at once
// one item at a time: s_tready is high only when the unit is idle and out of reset
// the result sits in an output register until m_tready takes it
// rst is synchronous and clears the sequencer only
`default_nettype none

module modular_add_mul_pow_unit #(
  parameter int WIDTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output      logic                                 s_tready,
  // [63:0] operand_a, [127:64] operand_b, [191:128] modulus
  input  wire logic [3*mamp_pkg::FIELD_W-1:0]       s_tdata,
  // [1:0] action
  input  wire logic [mamp_pkg::ACTION_W-1:0]        s_tuser,
  output      logic                                 m_tvalid,
  input  wire logic                                 m_tready,
  // [63:0] value
  output      logic [mamp_pkg::FIELD_W-1:0]         m_tdata,
  // [0] status
  output      logic                                 m_tuser
);

  localparam int CW = $clog2(WIDTH);
  localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

  // one lane of the modular adder: x + y mod m for x, y below m
  function automatic logic [WIDTH-1:0] madd(input logic [WIDTH-1:0] x,
                                            input logic [WIDTH-1:0] y,
                                            input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] gap;
    gap  = m - y;
    madd = (x >= gap) ? (x - gap) : (x + y);
  endfunction

  mamp_pkg::state_t state;

  logic [mamp_pkg::ACTION_W-1:0] act;
  logic [WIDTH-1:0] modn;       // modulus
  logic [WIDTH-1:0] opb;        // operand_b, kept for the second phase
  logic [WIDTH-1:0] src;        // bits still to shift into the remainder
  logic [WIDTH-1:0] rem;        // running remainder
  logic [WIDTH-1:0] xb;         // reduced operand_a
  logic [WIDTH-1:0] d;          // doubling addend
  logic [WIDTH-1:0] p1;         // partial product, lane 1
  logic [WIDTH-1:0] p2;         // partial product, lane 2 (squaring)
  logic [WIDTH-1:0] y1;         // multiplier bits, lane 1
  logic [WIDTH-1:0] y2;         // multiplier bits, lane 2
  logic [WIDTH-1:0] acc;        // power accumulator
  logic [WIDTH-1:0] e;          // exponent bits still to scan
  logic [CW-1:0]    cnt;        // step within a reduction or multiply
  logic [CW-1:0]    ecnt;       // exponent bit index
  logic [WIDTH-1:0] res_value;
  logic             res_status;

  // shared datapath
  logic [WIDTH:0]   red_t;
  logic [WIDTH:0]   red_sub;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] s1;
  logic [WIDTH-1:0] s2;
  logic [WIDTH-1:0] dd;
  logic [WIDTH-1:0] p1_step;
  logic [WIDTH-1:0] p2_step;
  logic [WIDTH-1:0] acc_new;
  logic [WIDTH-1:0] acc_init;
  logic [WIDTH-1:0] in_a;
  logic [WIDTH-1:0] in_b;
  logic [WIDTH-1:0] in_n;
  logic [mamp_pkg::FIELD_W-1:0] value_ext;

  assign in_a = s_tdata[0 +: WIDTH];
  assign in_b = s_tdata[mamp_pkg::FIELD_W +: WIDTH];
  assign in_n = s_tdata[2*mamp_pkg::FIELD_W +: WIDTH];

  // restoring remainder step: shift in the next bit, subtract if it fits
  always_comb begin
    red_t    = {rem, src[WIDTH-1]};
    red_sub  = red_t - {1'b0, modn};
    rem_next = (red_t >= {1'b0, modn}) ? red_sub[WIDTH-1:0] : red_t[WIDTH-1:0];
  end

  // three adder lanes: two product accumulations share one doubling addend
  always_comb begin
    s1      = madd(p1, d, modn);
    s2      = madd(p2, d, modn);
    dd      = madd(d, d, modn);
    p1_step = y1[0] ? s1 : p1;
    p2_step = y2[0] ? s2 : p2;
    acc_new = e[0] ? p1_step : acc;
    // a modulus of one leaves every result at zero
    acc_init = (modn == WIDTH'(1)) ? '0 : WIDTH'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mamp_pkg::S_IDLE;
    end else begin
      unique case (state)
        mamp_pkg::S_IDLE: begin
          if (s_tvalid) begin
            act  <= s_tuser;
            modn <= in_n;
            opb  <= in_b;
            src  <= in_a;
            rem  <= '0;
            cnt  <= '0;
            if (in_n == '0 || s_tuser == mamp_pkg::ACT_BAD) begin
              res_value  <= '0;
              res_status <= mamp_pkg::ST_BAD;
              state      <= mamp_pkg::S_DONE;
            end else begin
              state <= mamp_pkg::S_REDA;
            end
          end
        end
        mamp_pkg::S_REDA: begin
          rem <= rem_next;
          src <= src << 1;
          cnt <= cnt + CW'(1);
          if (cnt == LAST) begin
            xb  <= rem_next;
            cnt <= '0;
            unique case (act)
              mamp_pkg::ACT_ADD: begin
                src   <= opb;
                rem   <= '0;
                state <= mamp_pkg::S_REDB;
              end
              mamp_pkg::ACT_MUL: begin
                d     <= rem_next;
                y1    <= opb;
                y2    <= '0;
                p1    <= '0;
                p2    <= '0;
                state <= mamp_pkg::S_MUL;
              end
              default: begin
                // power: first round multiplies acc by x and squares x
                acc   <= acc_init;
                e     <= opb;
                ecnt  <= '0;
                d     <= rem_next;
                y1    <= acc_init;
                y2    <= rem_next;
                p1    <= '0;
                p2    <= '0;
                state <= mamp_pkg::S_MUL;
              end
            endcase
          end
        end
        mamp_pkg::S_REDB: begin
          rem <= rem_next;
          src <= src << 1;
          cnt <= cnt + CW'(1);
          if (cnt == LAST) begin
            // lane 1 forms the final sum
            p1    <= xb;
            d     <= rem_next;
            cnt   <= '0;
            state <= mamp_pkg::S_ADD;
          end
        end
        mamp_pkg::S_ADD: begin
          res_value  <= s1;
          res_status <= mamp_pkg::ST_OK;
          state      <= mamp_pkg::S_DONE;
        end
        mamp_pkg::S_MUL: begin
          p1  <= p1_step;
          p2  <= p2_step;
          d   <= dd;
          y1  <= y1 >> 1;
          y2  <= y2 >> 1;
          cnt <= cnt + CW'(1);
          if (cnt == LAST) begin
            cnt <= '0;
            if (act == mamp_pkg::ACT_MUL) begin
              res_value  <= p1_step;
              res_status <= mamp_pkg::ST_OK;
              state      <= mamp_pkg::S_DONE;
            end else begin
              acc  <= acc_new;
              e    <= e >> 1;
              ecnt <= ecnt + CW'(1);
              if (ecnt == LAST) begin
                res_value  <= acc_new;
                res_status <= mamp_pkg::ST_OK;
                state      <= mamp_pkg::S_DONE;
              end else begin
                // next exponent bit with the squared base
                d  <= p2_step;
                y1 <= acc_new;
                y2 <= p2_step;
                p1 <= '0;
                p2 <= '0;
              end
            end
          end
        end
        mamp_pkg::S_DONE: begin
          if (m_tready) begin
            state <= mamp_pkg::S_IDLE;
          end
        end
        default: begin
          state <= mamp_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    value_ext              = '0;
    value_ext[WIDTH-1:0]   = res_value;
  end

  // no transfer is taken while reset is high
  assign s_tready = !rst && (state == mamp_pkg::S_IDLE);
  assign m_tvalid = (state == mamp_pkg::S_DONE);
  assign m_tdata  = value_ext;
  assign m_tuser  = res_status;

endmodule

`default_nettype wire

// ===== hw/rtl/mamp_check.sv =====
// port checker for the modular arithmetic unit, bound to the top level
`default_nettype none

`include "modular_add_mul_pow_unit_defines.svh"

module mamp_check (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic [3*mamp_pkg::FIELD_W-1:0]     s_tdata,
  input wire logic [mamp_pkg::ACTION_W-1:0]      s_tuser,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [mamp_pkg::FIELD_W-1:0]       m_tdata,
  input wire logic                               m_tuser
);

  logic in_xfer;
  logic bad_item;

  assign in_xfer  = s_tvalid && s_tready;
  // a zero modulus or the unknown action is rejected at once
  assign bad_item = (s_tdata[2*mamp_pkg::FIELD_W +: mamp_pkg::FIELD_W] == '0) ||
                    (s_tuser == mamp_pkg::ACT_BAD);

  // an error result always carries a zero value
  `MAMP_ASSERT_NOW(a_bad_zero, clk, rst, m_tvalid && (m_tuser == mamp_pkg::ST_BAD), m_tdata == '0, "error result with nonzero value")

  // no new item while a result waits
  `MAMP_ASSERT_NOW(a_one_item, clk, rst, m_tvalid, !s_tready, "input taken while result pending")

  // a rejected item reports bad input on the next cycle
  `MAMP_ASSERT_NEXT(a_bad_fast, clk, rst, in_xfer && bad_item, m_tvalid && (m_tuser == mamp_pkg::ST_BAD), "rejected item not reported")

  // a stalled result holds
  `MAMP_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind modular_add_mul_pow_unit mamp_check u_mamp_check (.*);

`default_nettype wire

// ===== tb/modular_add_mul_pow_unit_tb.sv =====
// testbench for the modular add, multiply and power unit: directed and random requests
module modular_add_mul_pow_unit_tb;

  // set several times above the slowest legal run
  localparam int CYCLE_LIMIT  = 2_000_000;
  // a zero modulus or unknown action answers at once, so a short tail is plenty
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 118;
  // the opening stretch of the random part runs with neither side idling
  localparam int CALM_ITEMS   = 40;
  localparam int IDLE_PCT     = 11;
  localparam int MAX_PRINTED  = 40;

  typedef logic [mamp_pkg::FIELD_W-1:0]  word_t;
  typedef logic [mamp_pkg::ACTION_W-1:0] action_t;

  typedef struct packed {
    word_t value;
    logic  status;
  } outcome_t;

  localparam word_t ALL_ONES = '1;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [3*mamp_pkg::FIELD_W-1:0] s_tdata  = '0;
  logic [mamp_pkg::ACTION_W-1:0]  s_tuser  = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [mamp_pkg::FIELD_W-1:0]   m_tdata;
  logic                           m_tuser;

  // predicted results, oldest first
  outcome_t    pending_outcomes[$];
  int unsigned idle_pct    = IDLE_PCT;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  modular_add_mul_pow_unit #(
    .WIDTH(mamp_pkg::FIELD_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: operands reduced first, sums kept overflow-safe, bit-serial
  // double-and-add for products and right-to-left square-and-multiply for powers
  // ---------------------------------------------------------------------------

  // (x + y) mod n for x, y already below n
  function automatic word_t mod_sum(word_t x, word_t y, word_t n);
    word_t gap;
    gap = n - y;
    return (x >= gap) ? x - gap : x + y;
  endfunction

  function automatic word_t mod_product(word_t x, word_t y, word_t n);
    word_t acc;
    acc = '0;
    x = x % n;
    y = y % n;
    for (int k = 0; k < mamp_pkg::FIELD_W; k++) begin
      if (y[0]) acc = mod_sum(acc, x, n);
      y = y >> 1;
      x = mod_sum(x, x, n);
    end
    return acc;
  endfunction

  // only called with n above one
  function automatic word_t mod_power(word_t base, word_t expo, word_t n);
    word_t acc;
    acc = word_t'(1);
    base = base % n;
    for (int k = 0; k < mamp_pkg::FIELD_W; k++) begin
      if (expo[0]) acc = mod_product(acc, base, n);
      expo = expo >> 1;
      base = mod_product(base, base, n);
    end
    return acc;
  endfunction

  function automatic outcome_t predict_outcome(action_t action, word_t a, word_t b, word_t n);
    outcome_t res;
    res.value  = '0;
    res.status = mamp_pkg::ST_OK;
    if (n == '0 || action == mamp_pkg::ACT_BAD) begin
      res.status = mamp_pkg::ST_BAD;
    end else begin
      case (action)
        mamp_pkg::ACT_ADD: res.value = mod_sum(a % n, b % n, n);
        mamp_pkg::ACT_MUL: res.value = mod_product(a, b, n);
        default: begin
          // a unit modulus yields zero even for a zero exponent
          res.value = (n == word_t'(1)) ? '0 : mod_power(a, b, n);
        end
      endcase
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and in-order comparison
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, word_t got, word_t want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= idle_pct);
  end

  // a transfer on the result side is taken at the rising edge with both lines high
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with nothing outstanding", m_tdata, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (m_tdata !== want.value)
          report_mismatch("value", m_tdata, want.value);
        if (m_tuser !== want.status)
          report_mismatch("status", word_t'(m_tuser), word_t'(want.status));
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("modular_add_mul_pow_unit_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // drives one request from a falling edge and returns at the edge that takes it;
  // tvalid stays high so a following request goes out back to back
  task automatic issue_request(action_t action, word_t a, word_t b, word_t n);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {n, b, a};
    do @(posedge clk); while (!s_tready);
    pending_outcomes.push_back(predict_outcome(action, a, b, n));
  endtask

  // mix of full-range, small, near-maximum and single-bit words
  function automatic word_t random_word();
    word_t w;
    w = {$urandom, $urandom};
    case ($urandom_range(5))
      0: w = word_t'($urandom_range(20));
      1: w = ALL_ONES - word_t'($urandom_range(20));
      2: w = word_t'(1) << $urandom_range(mamp_pkg::FIELD_W - 1);
      default: ;
    endcase
    return w;
  endfunction

  function automatic word_t random_modulus();
    case ($urandom_range(19))
      0:       return '0;
      1:       return word_t'(1);
      default: return random_word();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_each_action();
    issue_request(mamp_pkg::ACT_ADD, 64'd7, 64'd9, 64'd10);
    issue_request(mamp_pkg::ACT_MUL, 64'd7, 64'd9, 64'd10);
    issue_request(mamp_pkg::ACT_POW, 64'd3, 64'd4, 64'd7);
    // operands above the modulus are reduced first
    issue_request(mamp_pkg::ACT_MUL, 64'd1000003, 64'd999983, 64'd97);
  endtask

  task automatic test_zero_modulus();
    issue_request(mamp_pkg::ACT_ADD, 64'd5, 64'd6, '0);
    issue_request(mamp_pkg::ACT_MUL, ALL_ONES, ALL_ONES, '0);
    issue_request(mamp_pkg::ACT_POW, 64'd2, 64'd10, '0);
  endtask

  task automatic test_unit_modulus();
    issue_request(mamp_pkg::ACT_ADD, ALL_ONES, 64'd3, word_t'(1));
    issue_request(mamp_pkg::ACT_MUL, 64'd12, 64'd34, word_t'(1));
    issue_request(mamp_pkg::ACT_POW, 64'd5, 64'd3, word_t'(1));
    // zero to the zero with a unit modulus still gives zero
    issue_request(mamp_pkg::ACT_POW, '0, '0, word_t'(1));
  endtask

  task automatic test_zero_exponent();
    issue_request(mamp_pkg::ACT_POW, 64'd123456789, '0, 64'd1000);
    issue_request(mamp_pkg::ACT_POW, '0, '0, 64'd13);
  endtask

  task automatic test_unknown_action();
    issue_request(mamp_pkg::ACT_BAD, 64'd5, 64'd6, 64'd7);
    issue_request(mamp_pkg::ACT_BAD, ALL_ONES, ALL_ONES, '0);
  endtask

  task automatic test_field_extremes();
    issue_request(mamp_pkg::ACT_ADD, ALL_ONES, ALL_ONES, ALL_ONES);
    // sum of two residues that would overflow the word
    issue_request(mamp_pkg::ACT_ADD, ALL_ONES - 1, ALL_ONES - 1, ALL_ONES);
    issue_request(mamp_pkg::ACT_ADD, '0, '0, ALL_ONES);
    issue_request(mamp_pkg::ACT_MUL, ALL_ONES - 1, ALL_ONES - 1, ALL_ONES);
    issue_request(mamp_pkg::ACT_MUL, ALL_ONES, ALL_ONES, ALL_ONES - 1);
    issue_request(mamp_pkg::ACT_POW, ALL_ONES - 1, ALL_ONES, ALL_ONES);
    issue_request(mamp_pkg::ACT_POW, '0, ALL_ONES, ALL_ONES);
  endtask

  task automatic test_random();
    action_t action;
    int unsigned pick;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_pct = (i < CALM_ITEMS) ? 0 : IDLE_PCT;
      pick = $urandom_range(99);
      if (pick < 30)      action = mamp_pkg::ACT_ADD;
      else if (pick < 60) action = mamp_pkg::ACT_MUL;
      else if (pick < 90) action = mamp_pkg::ACT_POW;
      else                action = mamp_pkg::ACT_BAD;
      issue_request(action, random_word(), random_word(), random_modulus());
    end
    idle_pct = IDLE_PCT;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_each_action();
    test_zero_modulus();
    test_unit_modulus();
    test_zero_exponent();
    test_unknown_action();
    test_field_extremes();
    test_random();

    @(negedge clk);
    s_tvalid <= 1'b0;
    // the watchdog covers a result that never arrives
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("modular_add_mul_pow_unit_tb: clean");
    end else begin
      $display("modular_add_mul_pow_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mamp_pkg.sv
hw/rtl/modular_add_mul_pow_unit.sv
hw/rtl/mamp_check.sv
tb/modular_add_mul_pow_unit_tb.sv
